/* rtl/btcs_pkg.sv */
// Shared constants, types and command/status structs for the byte trimmer.
// Used by the controller, the datapath and the top level.
package btcs_pkg;

  localparam int unsigned PENDING_DEPTH = 32;
  localparam int unsigned PTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SET_W = 64;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_LEFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM_RIGHT = 3'd5;

  typedef enum logic [1:0] {
    OSEL_RAM,
    OSEL_BYTE,
    OSEL_END
  } out_sel_e;

  typedef struct packed {
    logic     in_load;
    logic     rd_en;
    logic     pop;
    logic     push;
    logic     clear;
    logic     lead_clr;
    logic     lead_set;
    logic     out_load;
    out_sel_e out_sel;
    logic     out_ovf;
    logic     out_last_run;
  } dp_cmd_t;

  typedef struct packed {
    logic member;
    logic last;
    logic lead;
    logic trim_left;
    logic trim_right;
    logic cnt_zero;
    logic cnt_one;
    logic full;
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/byte_trim_character_set.sv */
// Byte trimmer against a 256-bit character set. A byte with its set bit is
// dropped at the start of a string (left trimming) and held in a pending queue
// of PENDING_DEPTH bytes (right trimming) until a non-member byte flushes it
// or the last byte of the string discards it. One input transaction is taken
// at a time. A queued byte that is flushed out is read through the queue's
// single registered read port, as is the oldest queued byte on an overflow.
// Results leave through an output register, so the next input transaction
// can be taken while a result still waits. The user must write configuration
// only while idle; the block itself does not enforce it.
// Depends on btcs_pkg, btcs_ctrl, btcs_dp, btcs_ram.
module byte_trim_character_set
  import btcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SET_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
  input  logic                 s_axis_tlast,  // last_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,  // [7:0] out_byte, [8] last_of_run, zero fill
  output logic [1:0]           m_axis_tuser,  // [0] byte_valid, [1] overflow
  output logic                 m_axis_tlast   // end_of_string
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [BYTE_W-1:0] out_byte;
  logic              out_bv, out_eos, out_lr, out_ovf;

  btcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  btcs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_byte_i       (s_axis_tdata),
    .in_last_i       (s_axis_tlast),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_byte_o      (out_byte),
    .out_byte_valid_o(out_bv),
    .out_eos_o       (out_eos),
    .out_last_run_o  (out_lr),
    .out_ovf_o       (out_ovf),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

  assign m_axis_tdata = {7'b0, out_lr, out_byte};
  assign m_axis_tuser = {out_ovf, out_bv};
  assign m_axis_tlast = out_eos;

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_bv) |-> (out_eos && out_lr && !out_ovf && out_byte == '0))
    else $error("bare end marker malformed");

  a_overflow_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_ovf) |-> (out_bv && !out_eos && out_lr))
    else $error("overflow result malformed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again before the transaction was decided");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.full |-> !stat.cnt_zero)
    else $error("pending queue count inconsistent");

endmodule

/* rtl/btcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/btcs_ctrl.sv */
// Controller state machine of the byte trimmer: sequences decide, flush,
// overflow and emit steps. Depends on btcs_pkg.
module btcs_ctrl
  import btcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_LOAD,
    ST_PUSH,
    ST_EMIT_BYTE,
    ST_EMIT_END
  } state_e;

  state_e state_q, state_d;
  logic   ovf_q, ovf_d;
  logic   drop;

  assign drop       = stat_i.trim_left & stat_i.lead & stat_i.member;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    ovf_d   = ovf_q;
    cmd_o   = '0;
    cmd_o.out_sel = OSEL_BYTE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ovf_d = 1'b0;
        if (drop) begin
          state_d = stat_i.last ? ST_EMIT_END : ST_IDLE;
        end else begin
          cmd_o.lead_clr = 1'b1;
          if (stat_i.trim_right && stat_i.member) begin
            if (stat_i.last) begin
              state_d = ST_EMIT_END;
            end else if (stat_i.full) begin
              ovf_d   = 1'b1;
              state_d = ST_READ;
            end else begin
              cmd_o.push = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            state_d = stat_i.cnt_zero ? ST_EMIT_BYTE : ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_sel      = OSEL_RAM;
          cmd_o.out_ovf      = ovf_q;
          cmd_o.out_last_run = ovf_q;
          cmd_o.pop          = 1'b1;
          if (ovf_q) begin
            state_d = ST_PUSH;
          end else if (stat_i.cnt_one) begin
            state_d = ST_EMIT_BYTE;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d = ST_IDLE;
      end
      ST_EMIT_BYTE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_sel      = OSEL_BYTE;
          cmd_o.out_last_run = 1'b1;
          cmd_o.clear        = stat_i.last;
          cmd_o.lead_set     = stat_i.last;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_END: begin
        if (stat_i.out_free) begin
          cmd_o.out_load     = 1'b1;
          cmd_o.out_sel      = OSEL_END;
          cmd_o.out_last_run = 1'b1;
          cmd_o.clear        = 1'b1;
          cmd_o.lead_set     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

/* rtl/btcs_dp.sv */
// Datapath of the byte trimmer: configuration, membership lookup, pending
// queue pointers and RAM, and the output register. Depends on btcs_pkg, btcs_ram.
module btcs_dp
  import btcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SET_W-1:0]     cfg_wdata_i,
  input  logic [BYTE_W-1:0]    in_byte_i,
  input  logic                 in_last_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [BYTE_W-1:0]    out_byte_o,
  output logic                 out_byte_valid_o,
  output logic                 out_eos_o,
  output logic                 out_last_run_o,
  output logic                 out_ovf_o,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PENDING_DEPTH);
  localparam logic [CNT_W:0] DEPTH_W_C = (CNT_W+1)'(PENDING_DEPTH);

  logic [3:0][SET_W-1:0] set_q;
  logic                  trim_l_q, trim_r_q;
  logic [BYTE_W-1:0]     byte_q;
  logic                  last_q, member_q, lead_q;
  logic [PTR_W-1:0]      head_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  oval_q;
  logic [BYTE_W-1:0]     obyte_q;
  logic                  obv_q, oeos_q, olr_q, oovf_q;

  logic [4*SET_W-1:0]    set_all;
  logic [PTR_W-1:0]      head_inc;
  logic [CNT_W:0]        wsum;
  logic [PTR_W-1:0]      waddr;
  logic [BYTE_W-1:0]     rdata;

  assign set_all  = set_q;
  assign head_inc = ({1'b0, head_q} == CNT_W'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign wsum     = (CNT_W+1)'(head_q) + (CNT_W+1)'(cnt_q);
  assign waddr    = (wsum >= DEPTH_W_C) ? PTR_W'(wsum - DEPTH_W_C) : PTR_W'(wsum);

  btcs_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(PENDING_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(waddr),
    .wdata_i(byte_q),
    .re_i   (cmd_i.rd_en),
    .raddr_i(head_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q    <= '0;
      trim_l_q <= 1'b1;
      trim_r_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS_0: set_q[0] <= cfg_wdata_i;
        CFG_SET_BITS_1: set_q[1] <= cfg_wdata_i;
        CFG_SET_BITS_2: set_q[2] <= cfg_wdata_i;
        CFG_SET_BITS_3: set_q[3] <= cfg_wdata_i;
        CFG_TRIM_LEFT:  trim_l_q <= cfg_wdata_i[0];
        CFG_TRIM_RIGHT: trim_r_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      byte_q   <= in_byte_i;
      last_q   <= in_last_i;
      member_q <= set_all[in_byte_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
      lead_q <= 1'b1;
    end else begin
      if (cmd_i.clear) begin
        head_q <= '0;
        cnt_q  <= '0;
      end else if (cmd_i.pop) begin
        head_q <= head_inc;
        cnt_q  <= cnt_q - 1'b1;
      end else if (cmd_i.push) begin
        cnt_q  <= cnt_q + 1'b1;
      end
      if (cmd_i.lead_set) begin
        lead_q <= 1'b1;
      end else if (cmd_i.lead_clr) begin
        lead_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      oval_q <= 1'b1;
    end else if (out_ready_i) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      olr_q  <= cmd_i.out_last_run;
      oovf_q <= cmd_i.out_ovf;
      case (cmd_i.out_sel)
        OSEL_RAM: begin
          obyte_q <= rdata;
          obv_q   <= 1'b1;
          oeos_q  <= 1'b0;
        end
        OSEL_BYTE: begin
          obyte_q <= byte_q;
          obv_q   <= 1'b1;
          oeos_q  <= last_q;
        end
        default: begin
          obyte_q <= '0;
          obv_q   <= 1'b0;
          oeos_q  <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o      = oval_q;
  assign out_byte_o       = obyte_q;
  assign out_byte_valid_o = obv_q;
  assign out_eos_o        = oeos_q;
  assign out_last_run_o   = olr_q;
  assign out_ovf_o        = oovf_q;

  assign stat_o.member     = member_q;
  assign stat_o.last       = last_q;
  assign stat_o.lead       = lead_q;
  assign stat_o.trim_left  = trim_l_q;
  assign stat_o.trim_right = trim_r_q;
  assign stat_o.cnt_zero   = (cnt_q == '0);
  assign stat_o.cnt_one    = (cnt_q == CNT_W'(1));
  assign stat_o.full       = (cnt_q >= DEPTH_C);
  assign stat_o.out_free   = !oval_q || out_ready_i;

endmodule
